@@ src/rbis_pkg.sv @@
// Shared constants for the random byte interval sampler.
package rbis_pkg;

    localparam int P_SIZE_BITS = 48;
    localparam int P_WORD      = 64;
    localparam int P_STEP_W    = $clog2(P_WORD);
    localparam int P_RATE_W    = 32;
    localparam int P_THR_W     = P_RATE_W + 1;
    localparam int P_CFG_IDX_W = 4;

    localparam logic [P_WORD-1:0]   P_GOLDEN_MIX   = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [P_WORD-1:0]   P_SCRAMBLE_MUL = 64'd2685821657736338717;
    localparam logic [P_RATE_W-1:0] P_DEFAULT_RATE = 32'd524288;

    localparam int P_SHIFT_A = 12;
    localparam int P_SHIFT_B = 25;
    localparam int P_SHIFT_C = 27;

    localparam logic [P_CFG_IDX_W-1:0] CFG_ENABLE      = 4'd0;
    localparam logic [P_CFG_IDX_W-1:0] CFG_SAMPLE_RATE = 4'd1;
    localparam logic [P_CFG_IDX_W-1:0] CFG_SEED        = 4'd2;
    localparam logic [P_CFG_IDX_W-1:0] CFG_STREAM_ID   = 4'd3;

endpackage

@@ src/rbis_mul.sv @@
// Bit-serial multiplier giving the low word of the state times the scramble constant.
module rbis_mul (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [rbis_pkg::P_WORD-1:0] i_x,
    output logic                       o_done,
    output logic [rbis_pkg::P_WORD-1:0] o_prod
);
    import rbis_pkg::*;

    logic                r_busy;
    logic                r_done;
    logic [P_STEP_W-1:0] r_cnt;
    logic [P_WORD-1:0]   r_acc;
    logic [P_WORD-1:0]   r_a;
    logic [P_WORD-1:0]   r_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == P_STEP_W'(P_WORD - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_a   <= i_x;
            r_b   <= P_SCRAMBLE_MUL;
        end else if (r_busy) begin
            if (r_b[0]) begin
                r_acc <= r_acc + r_a;
            end
            r_a <= {r_a[P_WORD-2:0], 1'b0};
            r_b <= {1'b0, r_b[P_WORD-1:1]};
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

@@ src/rbis_rem.sv @@
// Bit-serial restoring remainder of a word by the doubled sample rate.
module rbis_rem (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [rbis_pkg::P_WORD-1:0]  i_dvd,
    input  logic [rbis_pkg::P_THR_W-1:0] i_mod,
    output logic                        o_done,
    output logic [rbis_pkg::P_THR_W-1:0] o_rem
);
    import rbis_pkg::*;

    logic                r_busy;
    logic                r_done;
    logic [P_STEP_W-1:0] r_cnt;
    logic [P_THR_W-1:0]  r_rem;
    logic [P_THR_W-1:0]  r_mod;
    logic [P_WORD-1:0]   r_dvd;

    logic [P_THR_W:0]    w_trial;
    logic                w_ge;
    logic [P_THR_W-1:0]  n_rem;

    assign w_trial = {r_rem, r_dvd[P_WORD-1]};
    assign w_ge    = w_trial >= {1'b0, r_mod};
    assign n_rem   = w_ge ? P_THR_W'(w_trial - {1'b0, r_mod}) : w_trial[P_THR_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == P_STEP_W'(P_WORD - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_mod <= i_mod;
            r_dvd <= i_dvd;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_dvd <= {r_dvd[P_WORD-2:0], 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

@@ src/rbis_draw.sv @@
// Threshold draw: xorshift64 step, serial scramble multiply, serial remainder and clamp.
module rbis_draw (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic                         i_clear,
    input  logic [rbis_pkg::P_RATE_W-1:0] i_rate,
    input  logic [rbis_pkg::P_WORD-1:0]   i_seed,
    input  logic [rbis_pkg::P_WORD-1:0]   i_stream_id,
    output logic                         o_done,
    output logic [rbis_pkg::P_THR_W-1:0]  o_value
);
    import rbis_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_REM
    } t_state;

    t_state             r_state;
    logic [P_WORD-1:0]  r_prng;
    logic               r_done;
    logic [P_THR_W-1:0] r_value;

    logic [P_WORD-1:0]   w_x0;
    logic [P_WORD-1:0]   w_x1;
    logic [P_WORD-1:0]   w_x2;
    logic [P_WORD-1:0]   w_x3;
    logic [P_RATE_W-1:0] w_rate;
    logic [P_THR_W-1:0]  w_mod;
    logic                w_mul_done;
    logic [P_WORD-1:0]   w_prod;
    logic                w_rem_done;
    logic [P_THR_W-1:0]  w_rem;

    assign w_x0   = (r_prng == '0) ? (i_seed ^ i_stream_id ^ P_GOLDEN_MIX) : r_prng;
    assign w_x1   = w_x0 ^ (w_x0 >> P_SHIFT_A);
    assign w_x2   = w_x1 ^ (w_x1 << P_SHIFT_B);
    assign w_x3   = w_x2 ^ (w_x2 >> P_SHIFT_C);
    assign w_rate = (i_rate == '0) ? P_DEFAULT_RATE : i_rate;
    assign w_mod  = {w_rate, 1'b0};

    rbis_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start && (r_state == S_IDLE)),
        .i_x     (w_x3),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    rbis_rem u_rem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_done && (r_state == S_MUL)),
        .i_dvd   (w_prod),
        .i_mod   (w_mod),
        .o_done  (w_rem_done),
        .o_rem   (w_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_prng  <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_clear) begin
                        r_prng <= '0;
                    end else if (i_start) begin
                        r_prng  <= w_x3;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    if (w_mul_done) begin
                        r_state <= S_REM;
                    end
                end
                S_REM: begin
                    if (w_rem_done) begin
                        r_value <= (w_rem == '0) ? P_THR_W'(1) : w_rem;
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_done  = r_done;
    assign o_value = r_value;

endmodule

@@ src/random_byte_interval_sampler_unit.sv @@
// Top level of the random byte interval sampler: handshakes, byte counter and sequencing.
//
// Input channel i_valid/o_ready carries one allocation size per item; output channel
// o_valid/i_ready returns one result per item: the sampled flag and the threshold held.
// Configuration is a plain write port (enable, sample rate, seed, stream id); any write
// to a known register clears the generator state, byte counter and threshold.
// An item with a threshold already held and no hit needs no draw. Each threshold
// draw runs 64 steps of the bit-serial multiplier and then 64 steps of the
// bit-serial remainder unit. An item therefore needs no draw, one draw or two draws;
// a hit right after the first draw of a session needs two draws.
// One item is worked on at a time; o_ready is high only while the core is idle. A
// finished result sits in an output register, so the next item is taken while it
// waits; if the receiver stalls, the following item halts before its result is loaded.
// Reset clears the configuration to its defaults (disabled, rate 524288) and clears
// the session state; no clearing pass is needed.
module random_byte_interval_sampler_unit #(
    parameter int SIZE_BITS = rbis_pkg::P_SIZE_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [SIZE_BITS-1:0]            i_alloc_size,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic                            o_sampled,
    output logic [rbis_pkg::P_THR_W-1:0]    o_threshold_now,
    input  logic                            i_cfg_we,
    input  logic [rbis_pkg::P_CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [rbis_pkg::P_WORD-1:0]     i_cfg_wdata
);
    import rbis_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DRAW1,
        S_CHECK,
        S_DRAW2,
        S_DONE
    } t_state;

    t_state              r_state;
    logic                r_enable;
    logic [P_RATE_W-1:0] r_rate;
    logic [P_WORD-1:0]   r_seed;
    logic [P_WORD-1:0]   r_stream_id;
    logic [P_WORD-1:0]   r_count;
    logic [P_THR_W-1:0]  r_thr;
    logic                r_hit;
    logic                r_out_valid;
    logic                r_out_sampled;
    logic [P_THR_W-1:0]  r_out_thr;

    logic                w_accept;
    logic                w_cfg_hit;
    logic [P_WORD:0]     w_sum;
    logic [P_WORD-1:0]   w_sum_sat;
    logic                w_ge;
    logic                w_draw_start;
    logic                w_draw_done;
    logic [P_THR_W-1:0]  w_draw_val;

    assign o_ready   = (r_state == S_IDLE);
    assign w_accept  = i_valid && o_ready;
    assign w_cfg_hit = i_cfg_we && ((i_cfg_idx == CFG_ENABLE) || (i_cfg_idx == CFG_SAMPLE_RATE)
                       || (i_cfg_idx == CFG_SEED) || (i_cfg_idx == CFG_STREAM_ID));
    assign w_sum     = {1'b0, r_count} + {1'b0, P_WORD'(i_alloc_size)};
    assign w_sum_sat = w_sum[P_WORD] ? '1 : w_sum[P_WORD-1:0];
    assign w_ge      = r_count >= P_WORD'(r_thr);
    assign w_draw_start = (w_accept && r_enable && (r_thr == '0))
                          || ((r_state == S_CHECK) && w_ge);

    rbis_draw u_draw (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_draw_start),
        .i_clear     (w_cfg_hit),
        .i_rate      (r_rate),
        .i_seed      (r_seed),
        .i_stream_id (r_stream_id),
        .o_done      (w_draw_done),
        .o_value     (w_draw_val)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_enable    <= 1'b0;
            r_rate      <= P_DEFAULT_RATE;
            r_seed      <= '0;
            r_stream_id <= '0;
            r_count     <= '0;
            r_thr       <= '0;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            if (w_cfg_hit) begin
                unique case (i_cfg_idx)
                    CFG_ENABLE:      r_enable    <= i_cfg_wdata[0];
                    CFG_SAMPLE_RATE: r_rate      <= i_cfg_wdata[P_RATE_W-1:0];
                    CFG_SEED:        r_seed      <= i_cfg_wdata;
                    CFG_STREAM_ID:   r_stream_id <= i_cfg_wdata;
                    default:         r_enable    <= r_enable;
                endcase
                r_count <= '0;
                r_thr   <= '0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (r_enable) begin
                            r_count <= w_sum_sat;
                            r_state <= (r_thr == '0) ? S_DRAW1 : S_CHECK;
                        end else begin
                            r_hit   <= 1'b0;
                            r_state <= S_DONE;
                        end
                    end
                end
                S_DRAW1: begin
                    if (w_draw_done) begin
                        r_thr   <= w_draw_val;
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (w_ge) begin
                        r_hit   <= 1'b1;
                        r_count <= '0;
                        r_state <= S_DRAW2;
                    end else begin
                        r_hit   <= 1'b0;
                        r_state <= S_DONE;
                    end
                end
                S_DRAW2: begin
                    if (w_draw_done) begin
                        r_thr   <= w_draw_val;
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || i_ready) begin
                        r_out_valid   <= 1'b1;
                        r_out_sampled <= r_hit;
                        r_out_thr     <= r_thr;
                        r_state       <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid         = r_out_valid;
    assign o_sampled       = r_out_sampled;
    assign o_threshold_now = r_out_thr;

    a_hit_has_threshold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_sampled) |-> (o_threshold_now != '0))
        else $error("sampled result reports no threshold");

    a_draw_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_draw_done |-> ((r_state == S_DRAW1) || (r_state == S_DRAW2)))
        else $error("threshold draw finished outside a draw state");

    a_draw_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_draw_done |-> (w_draw_val != '0))
        else $error("drawn threshold is zero");

    a_check_has_threshold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHECK) |-> (r_thr != '0))
        else $error("counter compared against an empty threshold");

endmodule

@@ bench/sample_interval_checker.sv @@
// Checker that predicts and compares the sampled flag and threshold of every item.
module sample_interval_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  logic                             i_in_ready,
    input  logic [rbis_pkg::P_SIZE_BITS-1:0] i_alloc_size,
    input  logic                             i_out_valid,
    input  logic                             i_out_ready,
    input  logic                             i_sampled,
    input  logic [rbis_pkg::P_THR_W-1:0]     i_threshold_now,
    input  logic                             i_cfg_we,
    input  logic [rbis_pkg::P_CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [rbis_pkg::P_WORD-1:0]      i_cfg_wdata,
    output int                               o_waiting,
    output int                               o_errors
);
    timeunit 1ns;
    timeprecision 1ps;
    import rbis_pkg::*;

    typedef struct packed {
        logic               sampled;
        logic [P_THR_W-1:0] thr;
    } t_verdict;

    t_verdict expected_verdicts[$];

    logic                cfg_enable;
    logic [P_RATE_W-1:0] cfg_rate;
    logic [P_WORD-1:0]   cfg_seed;
    logic [P_WORD-1:0]   cfg_stream;

    logic [P_WORD-1:0]   gen_state;
    logic [P_WORD-1:0]   bytes_seen;
    logic [P_THR_W:0]    held_thr;

    function automatic void clear_session();
        gen_state  = '0;
        bytes_seen = '0;
        held_thr   = '0;
    endfunction

    function automatic logic [P_WORD-1:0] gen_next();
        logic [P_WORD-1:0] x;
        x = gen_state;
        if (x == '0) begin
            x = cfg_seed ^ cfg_stream ^ P_GOLDEN_MIX;
        end
        x = x ^ (x >> P_SHIFT_A);
        x = x ^ (x << P_SHIFT_B);
        x = x ^ (x >> P_SHIFT_C);
        gen_state = x;
        return x * P_SCRAMBLE_MUL;
    endfunction

    function automatic logic [P_THR_W:0] draw_interval();
        logic [P_WORD-1:0] rate;
        logic [P_WORD-1:0] v;
        rate = {32'd0, cfg_rate};
        if (rate == '0) begin
            rate = {32'd0, P_DEFAULT_RATE};
        end
        v = gen_next() % (rate * 64'd2);
        if (v < 64'd1) begin
            v = 64'd1;
        end
        if (v > rate * 64'd64) begin
            v = rate * 64'd64;
        end
        return v[P_THR_W:0];
    endfunction

    function automatic t_verdict predict_alloc(input logic [P_SIZE_BITS-1:0] size);
        t_verdict          r;
        logic [P_WORD-1:0] sz;
        sz = {{(P_WORD - P_SIZE_BITS){1'b0}}, size};
        r.sampled = 1'b0;
        if (cfg_enable) begin
            if (bytes_seen > ~64'd0 - sz) begin
                bytes_seen = '1;
            end else begin
                bytes_seen = bytes_seen + sz;
            end
            if (held_thr == '0) begin
                held_thr = draw_interval();
            end
            if (bytes_seen >= {{(P_WORD - P_THR_W - 1){1'b0}}, held_thr}) begin
                r.sampled  = 1'b1;
                bytes_seen = '0;
                held_thr   = draw_interval();
            end
        end
        r.thr = held_thr[P_THR_W-1:0];
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_verdict want;
        if (!i_rst_n) begin
            cfg_enable = 1'b0;
            cfg_rate   = P_DEFAULT_RATE;
            cfg_seed   = '0;
            cfg_stream = '0;
            clear_session();
            expected_verdicts.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ENABLE: begin
                        cfg_enable = i_cfg_wdata[0];
                        clear_session();
                    end
                    CFG_SAMPLE_RATE: begin
                        cfg_rate = i_cfg_wdata[P_RATE_W-1:0];
                        clear_session();
                    end
                    CFG_SEED: begin
                        cfg_seed = i_cfg_wdata;
                        clear_session();
                    end
                    CFG_STREAM_ID: begin
                        cfg_stream = i_cfg_wdata;
                        clear_session();
                    end
                    default: begin
                    end
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_verdicts.size() == 0) begin
                    $error("Result arrived with no item outstanding.");
                    o_errors = o_errors + 1;
                end else begin
                    want = expected_verdicts.pop_front();
                    if (i_sampled !== want.sampled) begin
                        $error("sampled mismatch: expected %0d, actual %0d",
                               want.sampled, i_sampled);
                        o_errors = o_errors + 1;
                    end
                    if (i_threshold_now !== want.thr) begin
                        $error("threshold_now mismatch: expected %0d, actual %0d",
                               want.thr, i_threshold_now);
                        o_errors = o_errors + 1;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                expected_verdicts.push_back(predict_alloc(i_alloc_size));
            end
        end
        o_waiting = expected_verdicts.size();
    end

endmodule

@@ bench/tb.sv @@
// Top-level testbench that drives stimulus into the sampler and reports the verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import rbis_pkg::*;

    localparam int N_PHASES = 16;
    localparam logic [P_CFG_IDX_W-1:0] CFG_IDX_LAST = '1;
    localparam logic [P_SIZE_BITS-1:0] SIZE_MAX = '1;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_valid;
    logic                   o_ready;
    logic [P_SIZE_BITS-1:0] i_alloc_size;
    logic                   o_valid;
    logic                   i_ready = 1'b0;
    logic                   o_sampled;
    logic [P_THR_W-1:0]     o_threshold_now;
    logic                   i_cfg_we;
    logic [P_CFG_IDX_W-1:0] i_cfg_idx;
    logic [P_WORD-1:0]      i_cfg_wdata;

    int                     pending_results;
    int                     mismatch_count;
    int                     tx_idle_pct;
    int                     rx_stall_pct;
    logic [P_RATE_W-1:0]    cur_rate;

    random_byte_interval_sampler_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_alloc_size    (i_alloc_size),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_sampled       (o_sampled),
        .o_threshold_now (o_threshold_now),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    sample_interval_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_valid),
        .i_in_ready      (o_ready),
        .i_alloc_size    (i_alloc_size),
        .i_out_valid     (o_valid),
        .i_out_ready     (i_ready),
        .i_sampled       (o_sampled),
        .i_threshold_now (o_threshold_now),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata),
        .o_waiting       (pending_results),
        .o_errors        (mismatch_count)
    );

    always #1 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        i_ready <= (rx_stall_pct == 0) || ($urandom_range(99, 0) >= rx_stall_pct);
    end

    function automatic logic [P_WORD-1:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [P_SIZE_BITS-1:0] pick_size();
        logic [P_WORD-1:0]      wide;
        logic [P_SIZE_BITS-1:0] s;
        wide = rand64();
        case ($urandom_range(15, 0))
            0: s = '0;
            1: s = SIZE_MAX;
            2, 3: s = wide[P_SIZE_BITS-1:0];
            default: s = P_SIZE_BITS'($urandom_range(cur_rate >> $urandom_range(3, 0), 0));
        endcase
        return s;
    endfunction

    task automatic send_size(input logic [P_SIZE_BITS-1:0] size);
        @(negedge i_clk);
        while (tx_idle_pct != 0 && $urandom_range(99, 0) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_alloc_size <= size;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_results != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [P_CFG_IDX_W-1:0] idx, input logic [P_WORD-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_SAMPLE_RATE) begin
            cur_rate = (data[P_RATE_W-1:0] == '0) ? P_DEFAULT_RATE : data[P_RATE_W-1:0];
        end
    endtask

    task automatic write_rate(input logic [P_RATE_W-1:0] rate);
        logic [P_WORD-1:0] w;
        w = rand64();
        w[P_RATE_W-1:0] = rate;
        write_reg(CFG_SAMPLE_RATE, w);
    endtask

    task automatic write_enable(input logic on);
        logic [P_WORD-1:0] w;
        w = rand64();
        w[0] = on;
        write_reg(CFG_ENABLE, w);
    endtask

    task automatic write_spare();
        logic [P_CFG_IDX_W-1:0] idx;
        idx = P_CFG_IDX_W'($urandom_range(CFG_IDX_LAST, CFG_STREAM_ID + 1));
        write_reg(idx, rand64());
    endtask

    task automatic write_zero_reseed(input logic [P_RATE_W-1:0] rate);
        logic [P_WORD-1:0] s;
        s = rand64();
        write_reg(CFG_SEED, s);
        write_reg(CFG_STREAM_ID, s ^ P_GOLDEN_MIX);
        write_rate(rate);
    endtask

    task automatic configure(input int variant);
        case (variant)
            0: begin
                write_rate($urandom_range(64, 1));
                write_enable(1'b1);
            end
            1: begin
                write_rate($urandom());
                write_reg(CFG_SEED, rand64());
                write_enable(1'b1);
            end
            2: begin
                write_rate('1);
                write_reg(CFG_STREAM_ID, rand64());
                write_enable(1'b1);
            end
            3: begin
                write_rate('0);
                write_reg(CFG_SEED, rand64());
                write_reg(CFG_STREAM_ID, rand64());
                write_enable(1'b1);
            end
            4: begin
                write_rate($urandom());
                write_enable(1'b0);
            end
            5: begin
                write_zero_reseed($urandom_range(5000, 1));
                write_enable(1'b1);
            end
            6: begin
                write_rate($urandom_range(100000, 100));
                write_reg(CFG_SEED, rand64());
                write_reg(CFG_STREAM_ID, rand64());
                write_enable(1'b1);
            end
            default: begin
                write_rate(32'd1);
                write_enable(1'b1);
            end
        endcase
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
            1: begin tx_idle_pct = 71; rx_stall_pct = 0;  end
            2: begin tx_idle_pct = 0;  rx_stall_pct = 71; end
            default: begin tx_idle_pct = 22; rx_stall_pct = 22; end
        endcase
    endtask

    initial begin
        #10_000_000;
        $display("FAIL");
        $finish;
    end

    initial begin
        int variant;
        int n_items;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_alloc_size = '0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = '0;
        i_cfg_wdata  = '0;
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        cur_rate     = P_DEFAULT_RATE;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Disabled out of reset: nothing is sampled.
        send_size('0);
        send_size(SIZE_MAX);
        drain();
        write_enable(1'b1);
        send_size(48'd1);
        send_size('0);
        send_size(SIZE_MAX);
        send_size(48'd1000);
        // A write to an unused index must leave the session alone.
        drain();
        write_spare();
        send_size(48'd5);
        send_size('0);
        drain();
        write_rate(32'd1);
        send_size('0);
        send_size('0);
        send_size(48'd1);
        // A zero rate falls back to the default.
        drain();
        write_rate('0);
        send_size(48'd1);
        send_size(SIZE_MAX);
        drain();
        write_reg(CFG_SEED, '1);
        write_reg(CFG_STREAM_ID, '1);
        write_rate('1);
        send_size(48'h1_0000_0000);
        send_size(SIZE_MAX);
        // The reseed value is zero, so every draw clamps to one.
        drain();
        write_zero_reseed(32'd3);
        send_size('0);
        send_size(48'd1);
        send_size(48'd1);
        drain();
        write_enable(1'b0);
        send_size(48'd7);

        for (int p = 0; p < N_PHASES; p++) begin
            variant = p % 8;
            n_items = (variant == 4) ? 30 : 130;
            drain();
            set_idling((p + p / 8) % 4);
            configure(variant);
            for (int n = 0; n < n_items; n++) begin
                if (n == n_items / 2) begin
                    drain();
                    write_spare();
                end
                send_size(pick_size());
            end
        end

        drain();
        repeat (300) @(negedge i_clk);
        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
